// File: rtl/rrq_pkg.sv
package rrq_pkg;

    localparam int THREAD_ID_W = 16;
    localparam int COUNT_W     = 5;

    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_DEQUEUE  = 2'd1,
        OP_SCHEDULE = 2'd2,
        OP_START    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_FULL       = 2'd2,
        ST_NO_CURRENT = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode                  opcode;
        logic [THREAD_ID_W-1:0]   thread_id;
        logic                     current_exited;
    } t_request;

    typedef struct packed {
        t_status                  status;
        logic [THREAD_ID_W-1:0]   current_id;
        logic                     current_valid;
        logic [COUNT_W-1:0]       queue_count;
    } t_result;

endpackage

// File: rtl/rrq_mem.sv
module rrq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/rrq_ctrl.sv
module rrq_ctrl
    import rrq_pkg::*;
#(
    parameter int MAX_THREADS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  t_request                       i_req,
    input  logic                           i_res_free,
    output logic                           o_res_valid,
    output t_result                        o_res,
    output logic                           o_mem_wr_en,
    output logic [$clog2(MAX_THREADS)-1:0] o_mem_wr_addr,
    output logic [ID_BITS-1:0]             o_mem_wr_data,
    output logic                           o_mem_rd_en,
    output logic [$clog2(MAX_THREADS)-1:0] o_mem_rd_addr,
    input  logic [ID_BITS-1:0]             i_mem_rd_data
);

    localparam int AW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FETCH,
        S_LOAD,
        S_DONE
    } t_state;

    t_state             r_state,    n_state;
    t_opcode            r_op,       n_op;
    logic [ID_BITS-1:0] r_id,       n_id;
    logic [CW-1:0]      r_len,      n_len;
    logic [AW-1:0]      r_slot,     n_slot;
    logic               r_present,  n_present;
    logic               r_detached, n_detached;
    logic [ID_BITS-1:0] r_held,     n_held;
    logic [CW-1:0]      r_issue,    n_issue;
    logic               r_pend,     n_pend;
    logic [AW-1:0]      r_pend_idx, n_pend_idx;
    logic [AW-1:0]      r_k,        n_k;
    t_status            r_status,   n_status;

    always_comb begin
        logic [CW-1:0] v_s;
        logic [CW-1:0] v_len;

        v_s        = '0;
        v_len      = '0;
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_len      = r_len;
        n_slot     = r_slot;
        n_present  = r_present;
        n_detached = r_detached;
        n_held     = r_held;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_k        = r_k;
        n_status   = r_status;

        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_len[AW-1:0];
        o_mem_wr_data = r_id;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_issue[AW-1:0];
        o_res_valid   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op   = i_req.opcode;
                    n_id   = ID_BITS'(i_req.thread_id);
                    n_pend = 1'b0;
                    unique case (i_req.opcode)
                        OP_ENQUEUE: begin
                            n_issue = '0;
                            n_state = S_SCAN;
                        end
                        OP_DEQUEUE: begin
                            // head slot is never a dequeue candidate
                            n_issue = CW'(1);
                            n_state = S_SCAN;
                        end
                        OP_SCHEDULE: begin
                            if (!r_present || r_len == '0) begin
                                n_status = ST_NO_CURRENT;
                                n_state  = S_DONE;
                            end else if (r_detached) begin
                                // successor already sits at the current slot
                                n_detached = 1'b0;
                                v_s = CW'(r_slot);
                                if (v_s >= r_len) begin
                                    v_s = '0;
                                end
                                n_slot  = v_s[AW-1:0];
                                n_state = S_FETCH;
                            end else if (i_req.current_exited) begin
                                n_k     = r_slot;
                                n_issue = CW'(r_slot) + CW'(1);
                                n_state = S_SHIFT;
                            end else begin
                                v_s = CW'(r_slot) + CW'(1);
                                if (v_s >= r_len) begin
                                    v_s = '0;
                                end
                                n_slot  = v_s[AW-1:0];
                                n_state = S_FETCH;
                            end
                        end
                        OP_START: begin
                            if (r_len == '0) begin
                                n_status = ST_NO_CURRENT;
                                n_state  = S_DONE;
                            end else begin
                                n_slot     = '0;
                                n_present  = 1'b1;
                                n_detached = 1'b0;
                                n_state    = S_FETCH;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN: begin
                if (r_pend && i_mem_rd_data == r_id) begin
                    n_pend = 1'b0;
                    if (r_op == OP_DEQUEUE) begin
                        n_k     = r_pend_idx;
                        n_issue = CW'(r_pend_idx) + CW'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end else if (r_issue < r_len) begin
                    o_mem_rd_en = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_issue[AW-1:0];
                    n_issue     = r_issue + CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    if (r_op == OP_DEQUEUE) begin
                        n_status = ST_NOT_FOUND;
                    end else if (r_len >= CW'(MAX_THREADS)) begin
                        n_status = ST_FULL;
                    end else begin
                        o_mem_wr_en = 1'b1;
                        n_len       = r_len + CW'(1);
                        n_status    = ST_OK;
                    end
                end
            end

            S_SHIFT: begin
                // read slot j, write it back into slot j-1 in the following cycle
                if (r_pend) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = r_pend_idx - AW'(1);
                    o_mem_wr_data = i_mem_rd_data;
                end
                if (r_issue < r_len) begin
                    o_mem_rd_en = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_issue[AW-1:0];
                    n_issue     = r_issue + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    v_len  = r_len - CW'(1);
                    n_len  = v_len;
                    if (r_op == OP_DEQUEUE) begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                        if (r_present) begin
                            if (r_k < r_slot) begin
                                n_slot = r_slot - AW'(1);
                            end else if (r_k == r_slot && !r_detached) begin
                                n_detached = 1'b1;
                            end
                        end
                    end else if (v_len == '0) begin
                        n_present = 1'b0;
                        n_slot    = '0;
                        n_held    = '0;
                        n_status  = ST_NO_CURRENT;
                        n_state   = S_DONE;
                    end else begin
                        v_s = CW'(r_k);
                        if (v_s >= v_len) begin
                            v_s = '0;
                        end
                        n_slot  = v_s[AW-1:0];
                        n_state = S_FETCH;
                    end
                end
            end

            S_FETCH: begin
                o_mem_rd_en   = 1'b1;
                o_mem_rd_addr = r_slot;
                n_state       = S_LOAD;
            end

            S_LOAD: begin
                n_held   = i_mem_rd_data;
                n_status = ST_OK;
                n_state  = S_DONE;
            end

            S_DONE: begin
                if (i_res_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_slot     <= '0;
            r_present  <= 1'b0;
            r_detached <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_slot     <= n_slot;
            r_present  <= n_present;
            r_detached <= n_detached;
            r_pend     <= n_pend;
        end
        r_op       <= n_op;
        r_id       <= n_id;
        r_held     <= n_held;
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_k        <= n_k;
        r_status   <= n_status;
    end

    assign o_req_ready         = (r_state == S_IDLE);
    assign o_res.status        = r_status;
    assign o_res.current_id    = r_present ? THREAD_ID_W'(r_held) : '0;
    assign o_res.current_valid = r_present;
    assign o_res.queue_count   = COUNT_W'(r_len);

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CW'(MAX_THREADS))
        else $error("queue length above capacity");

    a_present_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_present |-> r_len != '0)
        else $error("current thread with empty queue");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_present && !r_detached) |-> CW'(r_slot) < r_len)
        else $error("attached current slot past end of queue");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !o_mem_wr_en)
        else $error("queue memory written outside an operation");
`endif

endmodule

// File: rtl/round_robin_run_queue_unit.sv
// channel   direction  handshake                  payload
// ------    ---------  -------------------------  ----------------------------------------
// in        input      i_in_valid / o_in_stall    i_opcode, i_thread_id, i_current_exited
// out       output     o_out_valid / i_out_stall  o_status, o_current_id, o_current_valid,
//                                                 o_queue_count
//
// one operation at a time; enqueue scans the ids through the memory before it appends,
// dequeue scans up to the match, then compacts the slots behind it
// schedule fetches the next id, after compacting the slots when the exiting thread is removed
// start fetches the head id; all steps share the single read/write port pair of the id memory
// synchronous active-low reset empties the queue; the id memory itself is not cleared
// a result waits in the output register while the next transfer is accepted
module round_robin_run_queue_unit
    import rrq_pkg::*;
#(
    parameter int MAX_THREADS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_opcode,
    input  logic [THREAD_ID_W-1:0] i_thread_id,
    input  logic                   i_current_exited,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [THREAD_ID_W-1:0] o_current_id,
    output logic                   o_current_valid,
    output logic [COUNT_W-1:0]     o_queue_count
);

    localparam int AW = $clog2(MAX_THREADS);

    t_request           req;
    t_result            res;
    logic               req_ready;
    logic               res_valid;
    logic               res_free;

    // id memory port signals
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [ID_BITS-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [ID_BITS-1:0] mem_rd_data;

    // output register
    logic               r_out_valid;
    t_result            r_out;

    assign req.opcode         = t_opcode'(i_opcode);
    assign req.thread_id      = i_thread_id;
    assign req.current_exited = i_current_exited;

    assign o_in_stall = !req_ready;

    // the sequencer may hand over a result when the output slot is empty or drains this cycle
    assign res_free = !r_out_valid || !i_out_stall;

    rrq_ctrl #(
        .MAX_THREADS (MAX_THREADS),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_in_valid),
        .o_req_ready   (req_ready),
        .i_req         (req),
        .i_res_free    (res_free),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    rrq_mem #(
        .DEPTH (MAX_THREADS),
        .WIDTH (ID_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // result register: loads on a finished operation, clears on an output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_current_id    = r_out.current_id;
    assign o_current_valid = r_out.current_valid;
    assign o_queue_count   = r_out.queue_count;

endmodule
